[rtl/bsrb_pkg.sv]
// shared types and constants for the byte stream reorder buffer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bsrb_pkg;

   localparam int WINDOW_BYTES = 4096;
   localparam int ADDR_W       = $clog2(WINDOW_BYTES);
   localparam int DEPTH        = 1 << ADDR_W;
   localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);

   localparam int OP_W    = 2;
   localparam int POS_W   = 64;
   localparam int BYTE_W  = 8;
   localparam int SPACE_W = 13;
   localparam int PEND_W  = 13;

   localparam logic [OP_W-1:0] OP_SEGMENT  = 2'd0;
   localparam logic [OP_W-1:0] OP_END_MARK = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAIN    = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } slot_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      slot_type          wr_data;
   } mem_req_type;

endpackage

[rtl/byte_stream_reorder_buffer_unit.sv]
// top level of the byte stream reorder buffer
// depends on bsrb_pkg, bsrb_window_mem and bsrb_engine
`timescale 1ns / 1ps

//  channel  | direction | handshake             | payload
//  req_     | in        | req_valid / req_ready | op, stream_index, data_byte, ends_stream,
//           |           |                       | free_space
//  rsp_     | out       | rsp_valid / rsp_ready | has_byte, out_byte, stream_closed,
//           |           |                       | pending_count (one word per drain)
//
// per word, the accept cycle issues the window read, then the exec state takes the
// registered read data and writes the slot back where the word changes it
// a drain word stays in exec while the result register is full and rsp_ready is low
// after reset a clearing pass over all DEPTH (4096) slots runs with req_ready low
// reset is synchronous and active high

module byte_stream_reorder_buffer_unit
   import bsrb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_op,
   input  logic [POS_W-1:0]   req_stream_index,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_ends_stream,
   input  logic [SPACE_W-1:0] req_free_space,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_byte,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_stream_closed,
   output logic [PEND_W-1:0]  rsp_pending_count
);

   mem_req_type mem_req;
   slot_type    rd_data;
   logic        init_done;

   bsrb_window_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .init_done (init_done)
   );

   bsrb_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_stream_index  (req_stream_index),
      .req_data_byte     (req_data_byte),
      .req_ends_stream   (req_ends_stream),
      .req_free_space    (req_free_space),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_stream_closed (rsp_stream_closed),
      .rsp_pending_count (rsp_pending_count),
      .mem_req           (mem_req),
      .rd_data           (rd_data),
      .init_done         (init_done)
   );

endmodule

[rtl/bsrb_window_mem.sv]
// ring window memory: one valid bit and one byte per slot, registered read
// clears every slot once after reset; depends on bsrb_pkg
`timescale 1ns / 1ps

module bsrb_window_mem
   import bsrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output slot_type    rd_data,
   output logic        init_done
);

   slot_type          mem [DEPTH];
   slot_type          rd_data_ff;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign init_done = !clearing_ff;

endmodule

[rtl/bsrb_engine.sv]
// word sequencer: window checks, read-modify-write of one slot, result register
// depends on bsrb_pkg; drives bsrb_window_mem through a mem_req_type struct
`timescale 1ns / 1ps

module bsrb_engine
   import bsrb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_op,
   input  logic [POS_W-1:0]   req_stream_index,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_ends_stream,
   input  logic [SPACE_W-1:0] req_free_space,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_byte,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_stream_closed,
   output logic [PEND_W-1:0]  rsp_pending_count,
   output mem_req_type        mem_req,
   input  slot_type           rd_data,
   input  logic               init_done
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic              state_ff, state_in;
   logic [POS_W-1:0]  next_ff, next_in;
   logic              end_known_ff, end_known_in;
   logic [POS_W-1:0]  end_pos_ff, end_pos_in;
   logic [CNT_W-1:0]  held_ff, held_in;

   // captured word, plus compares done while the slot is being read
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] slot_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              in_win_ff;
   logic [POS_W-1:0]  nplus_ff;
   logic              ge0_ff, ge1_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              has_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              closed_ff;
   logic [PEND_W-1:0] pend_ff;

   logic              accept;
   logic [POS_W-1:0]  diff;
   logic [POS_W-1:0]  space64;
   logic [POS_W-1:0]  lim;
   logic              in_win;
   logic [POS_W-1:0]  nplus;
   logic [ADDR_W-1:0] addr_sel;
   logic              blocked;
   logic              commit;
   logic              seg_write;
   logic              drain_take;
   logic              drain_done;

   assign req_ready = (state_ff == ST_IDLE) && init_done;
   assign accept    = req_valid && req_ready;

   assign diff    = req_stream_index - next_ff;
   assign space64 = POS_W'(req_free_space);
   assign lim     = (space64 < POS_W'(WINDOW_BYTES)) ? space64 : POS_W'(WINDOW_BYTES);
   assign in_win  = (req_stream_index >= next_ff) && (diff < lim);
   assign nplus   = next_ff + 64'd1;

   assign addr_sel = (req_op == OP_DRAIN) ? next_ff[ADDR_W-1:0]
                                          : req_stream_index[ADDR_W-1:0];

   // a drain holds in exec until the result register can take it
   assign blocked    = rsp_valid_ff && !rsp_ready;
   assign commit     = (state_ff == ST_EXEC) && !((op_ff == OP_DRAIN) && blocked);
   assign seg_write  = commit && (op_ff == OP_SEGMENT) && in_win_ff && !rd_data.valid;
   assign drain_done = commit && (op_ff == OP_DRAIN);
   assign drain_take = drain_done && rd_data.valid;

   always_comb begin
      mem_req.rd_en        = accept && ((req_op == OP_SEGMENT) || (req_op == OP_DRAIN));
      mem_req.rd_addr      = addr_sel;
      mem_req.wr_en        = seg_write || drain_take;
      mem_req.wr_addr      = slot_ff;
      mem_req.wr_data.valid = seg_write;
      mem_req.wr_data.data = byte_ff;
   end

   always_comb begin
      state_in     = state_ff;
      next_in      = next_ff;
      end_known_in = end_known_ff;
      end_pos_in   = end_pos_ff;
      held_in      = held_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               if ((req_op == OP_SEGMENT) && req_ends_stream) begin
                  end_known_in = 1'b1;
                  end_pos_in   = req_stream_index + 64'd1;
               end else if (req_op == OP_END_MARK) begin
                  end_known_in = 1'b1;
                  end_pos_in   = req_stream_index;
               end
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
            if (seg_write) begin
               held_in = held_ff + 1'b1;
            end else if (drain_take) begin
               next_in = nplus_ff;
               if (held_ff != '0) begin
                  held_in = held_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = drain_done ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_ff      <= '0;
         end_known_ff <= 1'b0;
         end_pos_ff   <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         end_known_ff <= end_known_in;
         end_pos_ff   <= end_pos_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         slot_ff   <= addr_sel;
         byte_ff   <= req_data_byte;
         in_win_ff <= in_win;
         nplus_ff  <= nplus;
         ge0_ff    <= next_ff >= end_pos_ff;
         ge1_ff    <= nplus >= end_pos_ff;
      end
      if (drain_done) begin
         has_ff      <= rd_data.valid;
         out_byte_ff <= rd_data.valid ? rd_data.data : '0;
         closed_ff   <= end_known_ff && (rd_data.valid ? ge1_ff : ge0_ff);
         pend_ff     <= PEND_W'(held_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_has_byte      = has_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_stream_closed = closed_ff;
   assign rsp_pending_count = pend_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> init_done)
      else $error("word accepted during window clearing pass");

   a_write_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == ST_EXEC))
      else $error("window write outside exec state");

   a_drain_advances: assert property (@(posedge clock) disable iff (reset)
      drain_take |=> (next_ff == $past(next_ff) + 64'd1))
      else $error("in-order position did not advance after a released byte");

   a_held_bounded: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(WINDOW_BYTES))
      else $error("held byte count exceeds window size");

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(op_ff) == OP_DRAIN))
      else $error("result word raised by a non-drain word");
`endif

endmodule
